>>> hw/rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Types, microcode format and control store for the leftmost binary search.
// ----------------------------------------------------------------------------
package lbs_pkg;

    // fixed field widths of the item interfaces
    localparam int OPCODE_W      = 1;
    localparam int ENTRY_INDEX_W = 8;
    localparam int DATA_W        = 32;
    localparam int ENTRY_COUNT_W = 9;
    localparam int POSITION_W    = 8;

    // item opcodes
    localparam logic [OPCODE_W-1:0] OPC_WRITE  = 1'b0;
    localparam logic [OPCODE_W-1:0] OPC_SEARCH = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } in_item_t;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } out_item_t;

    // microcode step addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] ST_INIT     = 4'd1;
    localparam logic [UPC_W-1:0] ST_PROBE    = 4'd2;
    localparam logic [UPC_W-1:0] ST_CMP      = 4'd3;
    localparam logic [UPC_W-1:0] ST_TEST     = 4'd4;
    localparam logic [UPC_W-1:0] ST_MISS     = 4'd5;
    localparam logic [UPC_W-1:0] ST_BACK_RD  = 4'd6;
    localparam logic [UPC_W-1:0] ST_BACK_CMP = 4'd7;
    localparam logic [UPC_W-1:0] ST_HIT      = 4'd8;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_INIT  = 3'd1;
    localparam logic [OP_W-1:0] OP_PROBE = 3'd2;
    localparam logic [OP_W-1:0] OP_CMP   = 3'd3;
    localparam logic [OP_W-1:0] OP_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd5;
    localparam logic [OP_W-1:0] OP_HIT   = 3'd6;
    localparam logic [OP_W-1:0] OP_MISS  = 3'd7;

    // jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER  = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
    localparam logic [COND_W-1:0] C_NO_GO  = 3'd2;
    localparam logic [COND_W-1:0] C_EMPTY  = 3'd3;
    localparam logic [COND_W-1:0] C_EQ     = 3'd4;
    localparam logic [COND_W-1:0] C_CONT   = 3'd5;
    localparam logic [COND_W-1:0] C_AT_LO  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic              wait_out;
        logic [UPC_W-1:0]  target;
    } ctrl_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic empty;
        logic eq;
        logic cont;
        logic at_lo;
    } stat_t;

    // control store: jump to target when cond holds, otherwise next step
    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, wait_out: 1'b0, target: ST_IDLE};
        case (addr)
            ST_IDLE:     w = '{op: OP_NONE,  cond: C_NO_GO,  wait_out: 1'b0,
                               target: ST_IDLE};
            ST_INIT:     w = '{op: OP_INIT,  cond: C_EMPTY,  wait_out: 1'b0,
                               target: ST_MISS};
            ST_PROBE:    w = '{op: OP_PROBE, cond: C_NEVER,  wait_out: 1'b0,
                               target: ST_IDLE};
            ST_CMP:      w = '{op: OP_CMP,   cond: C_EQ,     wait_out: 1'b0,
                               target: ST_BACK_RD};
            ST_TEST:     w = '{op: OP_NONE,  cond: C_CONT,   wait_out: 1'b0,
                               target: ST_PROBE};
            ST_MISS:     w = '{op: OP_MISS,  cond: C_ALWAYS, wait_out: 1'b1,
                               target: ST_IDLE};
            ST_BACK_RD:  w = '{op: OP_BACK,  cond: C_AT_LO,  wait_out: 1'b0,
                               target: ST_HIT};
            ST_BACK_CMP: w = '{op: OP_DEC,   cond: C_EQ,     wait_out: 1'b0,
                               target: ST_BACK_RD};
            ST_HIT:      w = '{op: OP_HIT,   cond: C_ALWAYS, wait_out: 1'b1,
                               target: ST_IDLE};
            default:     w = '{op: OP_NONE,  cond: C_ALWAYS, wait_out: 1'b0,
                               target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/lbs_datapath.sv
// ----------------------------------------------------------------------------
// lbs_datapath
// Entry table, search bounds, probe index and key compare, driven one
// control word per cycle by the sequencer.
// ----------------------------------------------------------------------------
module lbs_datapath
    import lbs_pkg::*;
#(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  ctrl_t                    ctrl,
    input  logic                     wr_en,
    input  logic                     key_load,
    input  in_item_t                 item,
    input  logic [ENTRY_COUNT_W-1:0] entry_count,
    output stat_t                    stat,
    output logic [POSITION_W-1:0]    position
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [IDX_W-1:0]       lo_reg;
    logic [IDX_W-1:0]       hi_reg;
    logic [IDX_W-1:0]       mid_reg;
    logic                   stop_reg;

    logic [IDX_W-1:0]       wrap_lut [256];
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;
    logic [IDX_W:0]         bound_sum;
    logic [IDX_W-1:0]       mid_calc;
    logic [CMP_W-1:0]       count_wide;
    logic [CNT_W-1:0]       count_eff;
    logic signed [63:0]     value_ext;
    logic signed [63:0]     key_ext;
    logic                   eq;
    logic                   lt;

    // write index wraps modulo the table depth
    for (genvar g = 0; g < 256; g++) begin : g_wrap
        assign wrap_lut[g] = IDX_W'(g % DEPTH);
    end
    assign wr_addr = wrap_lut[item.entry_index];

    // 32-bit inputs brought to the stored width
    assign value_ext = 64'(item.entry_value);
    assign key_ext   = 64'(item.search_key);

    // entries in use, clamped to the table
    assign count_wide = CMP_W'(entry_count);
    assign count_eff  = (count_wide > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(count_wide);

    // probe point and read address
    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = bound_sum[IDX_W:1];
    assign rd_en     = (ctrl.op == OP_PROBE) || (ctrl.op == OP_BACK);
    assign rd_addr   = (ctrl.op == OP_PROBE) ? mid_calc : mid_reg - IDX_W'(1);

    // table storage with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= value_ext[VALUE_WIDTH-1:0];
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // key compare
    assign eq = (rd_data_reg == key_reg);
    assign lt = $signed(rd_data_reg) < $signed(key_reg);

    // search bounds and probe index
    always_ff @(posedge aclk) begin
        if (key_load) begin
            key_reg <= key_ext[VALUE_WIDTH-1:0];
        end
        case (ctrl.op)
            OP_INIT: begin
                lo_reg <= '0;
                hi_reg <= IDX_W'(count_eff - CNT_W'(1));
            end
            OP_PROBE: begin
                mid_reg <= mid_calc;
            end
            OP_CMP: begin
                if (!eq) begin
                    if (lt) begin
                        lo_reg   <= mid_reg + IDX_W'(1);
                        stop_reg <= (mid_reg >= hi_reg);
                    end else begin
                        hi_reg   <= mid_reg - IDX_W'(1);
                        stop_reg <= (mid_reg <= lo_reg);
                    end
                end
            end
            OP_DEC: begin
                if (eq) begin
                    mid_reg <= mid_reg - IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign stat.empty = (count_eff == '0);
    assign stat.eq    = eq;
    assign stat.cont  = !stop_reg;
    assign stat.at_lo = (mid_reg == lo_reg);
    assign position   = POSITION_W'(mid_reg);

endmodule

>>> hw/rtl/leftmost_binary_search.sv
// Search: p probes on a miss, p probes and then backward steps over the e equal
// entries on a hit; p is zero for an empty table, at most floor(log2(n)) + 1 for n
// entries in use.
// Write: no result; the table has one read port, so each probe and each
// backward step is one read followed by one compare step of the microprogram.
// Reset: entry_count cleared, sequencer idle, no result; table undefined.
// ----------------------------------------------------------------------------
// leftmost_binary_search
// Microcoded leftmost binary search over a software-written sorted table.
// ----------------------------------------------------------------------------
module leftmost_binary_search
    import lbs_pkg::*;
#(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ENTRY_COUNT_W-1:0] cfg_data
);

    logic [UPC_W-1:0]         upc_reg;
    logic [UPC_W-1:0]         upc_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    out_item_t                m_data_reg;

    ctrl_t                    ctrl;
    stat_t                    stat;
    logic [POSITION_W-1:0]    position;
    logic                     s_xfer;
    logic                     search_go;
    logic                     out_free;
    logic                     out_load;
    logic                     cond_true;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            entry_count_reg <= cfg_data;
        end
    end

    // input transfer only while the sequencer rests
    assign ctrl      = ucode_rom(upc_reg);
    assign s_ready   = (upc_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign search_go = s_xfer && (s_data.opcode == OPC_SEARCH);

    lbs_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .wr_en       (s_xfer && (s_data.opcode == OPC_WRITE)),
        .key_load    (search_go),
        .item        (s_data),
        .entry_count (entry_count_reg),
        .stat        (stat),
        .position    (position)
    );

    // jump condition select
    always_comb begin
        case (ctrl.cond)
            C_NEVER:  cond_true = 1'b0;
            C_ALWAYS: cond_true = 1'b1;
            C_NO_GO:  cond_true = !search_go;
            C_EMPTY:  cond_true = stat.empty;
            C_EQ:     cond_true = stat.eq;
            C_CONT:   cond_true = stat.cont;
            C_AT_LO:  cond_true = stat.at_lo;
            default:  cond_true = 1'b1;
        endcase
    end

    // step counter: hold while a result step waits for the output register
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ctrl.wait_out && out_free;

    always_comb begin
        if (ctrl.wait_out && !out_free) begin
            upc_next = upc_reg;
        end else if (cond_true) begin
            upc_next = ctrl.target;
        end else begin
            upc_next = upc_reg + UPC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // result register
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.found    <= (ctrl.op == OP_HIT);
            m_data_reg.position <= (ctrl.op == OP_HIT) ? position : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hw/rtl/lbs_checker.sv
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks of the leftmost binary search, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker
    import lbs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.position == '0)
        else $error("miss with nonzero position");

    // a result rises only after search work, never straight out of idle
    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    // a write transfer never produces a result
    a_write_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OPC_WRITE) && !m_valid |=> !m_valid)
        else $error("write transfer produced a result");

endmodule

bind leftmost_binary_search lbs_checker u_lbs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
